// File: sv/lksm_pkg.sv
// lksm_pkg: shared types and constants for the lru key slot map
// command, status and action codes, fsm states, cell control word
// no dependencies
package lksm_pkg;

  // default sizes of the slot map
  localparam int unsigned DefEntries = 16;
  localparam int unsigned DefKeyBits = 32;

  // fixed port widths
  localparam int unsigned CmdW     = 3;
  localparam int unsigned KeyInW   = 32;
  localparam int unsigned SlotInW  = 4;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_TOUCH  = 3'd2,
    CMD_DEMOTE = 3'd3,
    CMD_PIN    = 3'd4,
    CMD_FLUSH  = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISS     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // what the apply cycle does to the row of cells
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MRU,
    ACT_LRU,
    ACT_PIN,
    ACT_FLUSH
  } act_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_APPLY
  } fsm_e;

  // per-cell control for the apply cycle
  typedef struct packed {
    logic load;     // take the injected entry
    logic take_hi;  // take the entry of the next more recent cell
    logic take_lo;  // take the entry of the next less recent cell
    logic flush;    // drop valid and pin
  } cell_ctrl_t;

endpackage

// File: sv/lksm_cell.sv
// lksm_cell: one recency position holding slot id, key, valid and pin
// shifts toward either neighbor or loads an injected entry
// depends on lksm_pkg
module lksm_cell #(
  parameter int unsigned SW  = 4,
  parameter int unsigned KW  = 32,
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lksm_pkg::cell_ctrl_t ctrl_i,
  input  logic [SW-1:0]       hi_id_i,
  input  logic [KW-1:0]       hi_key_i,
  input  logic                hi_valid_i,
  input  logic                hi_pin_i,
  input  logic [SW-1:0]       lo_id_i,
  input  logic [KW-1:0]       lo_key_i,
  input  logic                lo_valid_i,
  input  logic                lo_pin_i,
  input  logic [SW-1:0]       inj_id_i,
  input  logic [KW-1:0]       inj_key_i,
  input  logic                inj_valid_i,
  input  logic                inj_pin_i,
  output logic [SW-1:0]       id_o,
  output logic [KW-1:0]       key_o,
  output logic                valid_o,
  output logic                pin_o
);
  import lksm_pkg::*;

  logic [SW-1:0] id_q, id_d;
  logic [KW-1:0] key_q, key_d;
  logic          valid_q, valid_d;
  logic          pin_q, pin_d;

  // next entry: load wins over shifts, flush clears flags last
  always_comb begin
    id_d    = id_q;
    key_d   = key_q;
    valid_d = valid_q;
    pin_d   = pin_q;
    if (ctrl_i.load) begin
      id_d    = inj_id_i;
      key_d   = inj_key_i;
      valid_d = inj_valid_i;
      pin_d   = inj_pin_i;
    end else if (ctrl_i.take_hi) begin
      id_d    = hi_id_i;
      key_d   = hi_key_i;
      valid_d = hi_valid_i;
      pin_d   = hi_pin_i;
    end else if (ctrl_i.take_lo) begin
      id_d    = lo_id_i;
      key_d   = lo_key_i;
      valid_d = lo_valid_i;
      pin_d   = lo_pin_i;
    end
    if (ctrl_i.flush) begin
      valid_d = 1'b0;
      pin_d   = 1'b0;
    end
  end

  // slot id and flags, reset to ascending order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= SW'(IDX);
      valid_q <= 1'b0;
      pin_q   <= 1'b0;
    end else begin
      id_q    <= id_d;
      valid_q <= valid_d;
      pin_q   <= pin_d;
    end
  end

  // stored key
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign id_o    = id_q;
  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign pin_o   = pin_q;

endmodule

// File: sv/lksm_chain.sv
// lksm_chain: row of recency cells, position 0 least recent
// wires each cell to its two neighbors and to the shared inject entry
// depends on lksm_pkg, lksm_cell
module lksm_chain #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned SW      = 4,
  parameter int unsigned KW      = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lksm_pkg::cell_ctrl_t ctrl_i [ENTRIES],
  input  logic [SW-1:0]        inj_id_i,
  input  logic [KW-1:0]        inj_key_i,
  input  logic                 inj_valid_i,
  input  logic                 inj_pin_i,
  output logic [SW-1:0]        id_o    [ENTRIES],
  output logic [KW-1:0]        key_o   [ENTRIES],
  output logic                 valid_o [ENTRIES],
  output logic                 pin_o   [ENTRIES]
);
  import lksm_pkg::*;

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    logic [SW-1:0] hi_id, lo_id;
    logic [KW-1:0] hi_key, lo_key;
    logic          hi_valid, lo_valid, hi_pin, lo_pin;

    // more recent neighbor, none past the top
    if (p == ENTRIES - 1) begin : g_top
      assign hi_id    = inj_id_i;
      assign hi_key   = inj_key_i;
      assign hi_valid = inj_valid_i;
      assign hi_pin   = inj_pin_i;
    end else begin : g_hi
      assign hi_id    = id_o[p+1];
      assign hi_key   = key_o[p+1];
      assign hi_valid = valid_o[p+1];
      assign hi_pin   = pin_o[p+1];
    end

    // less recent neighbor, none below the bottom
    if (p == 0) begin : g_bot
      assign lo_id    = inj_id_i;
      assign lo_key   = inj_key_i;
      assign lo_valid = inj_valid_i;
      assign lo_pin   = inj_pin_i;
    end else begin : g_lo
      assign lo_id    = id_o[p-1];
      assign lo_key   = key_o[p-1];
      assign lo_valid = valid_o[p-1];
      assign lo_pin   = pin_o[p-1];
    end

    lksm_cell #(
      .SW (SW),
      .KW (KW),
      .IDX(p)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i[p]),
      .hi_id_i    (hi_id),
      .hi_key_i   (hi_key),
      .hi_valid_i (hi_valid),
      .hi_pin_i   (hi_pin),
      .lo_id_i    (lo_id),
      .lo_key_i   (lo_key),
      .lo_valid_i (lo_valid),
      .lo_pin_i   (lo_pin),
      .inj_id_i   (inj_id_i),
      .inj_key_i  (inj_key_i),
      .inj_valid_i(inj_valid_i),
      .inj_pin_i  (inj_pin_i),
      .id_o       (id_o[p]),
      .key_o      (key_o[p]),
      .valid_o    (valid_o[p]),
      .pin_o      (pin_o[p])
    );
  end

endmodule

// File: sv/lru_key_slot_map_core.sv
// lru_key_slot_map_core: fully associative key to slot map with lru replacement
// decodes commands, matches against the cell row and drives its shifts
// depends on lksm_pkg, lksm_chain, lksm_cell
//
//   channel   handshake          word
//   -------   ---------------    ----------------------------------------------
//   command   start / busy       command_i, key_i, slot_i
//   result    done_o (strobe)    status_o, slot_out_o, evicted_valid_o,
//                                evicted_key_o
//
// for each word, the accept edge registers the key match and the
// victim pick over all cells, the following apply cycle updates the recency row
// once; busy is high for that apply cycle only
// the result strobes for one cycle right after the apply cycle, while the next
// word may already be accepted; the receiver cannot stall
// reset is asynchronous and puts slots in ascending recency order, all invalid
module lru_key_slot_map_core #(
  parameter int unsigned ENTRIES  = lksm_pkg::DefEntries,
  parameter int unsigned KEY_BITS = lksm_pkg::DefKeyBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lksm_pkg::CmdW-1:0]       command_i,
  input  logic [lksm_pkg::KeyInW-1:0]     key_i,
  input  logic [lksm_pkg::SlotInW-1:0]    slot_i,
  output logic                            done_o,
  output logic [lksm_pkg::StatusW-1:0]    status_o,
  output logic [lksm_pkg::SlotInW-1:0]    slot_out_o,
  output logic                            evicted_valid_o,
  output logic [lksm_pkg::KeyInW-1:0]     evicted_key_o
);
  import lksm_pkg::*;

  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = (SW > SlotInW) ? SW : SlotInW;
  localparam int unsigned KW = KEY_BITS;

  fsm_e fsm_q, fsm_d;
  logic apply_en;
  logic accept;

  // cell row view
  cell_ctrl_t    ctrl      [ENTRIES];
  logic [SW-1:0] cell_id   [ENTRIES];
  logic [KW-1:0] cell_key  [ENTRIES];
  logic          cell_valid[ENTRIES];
  logic          cell_pin  [ENTRIES];

  // match vectors at accept
  logic [ENTRIES-1:0] hit_v, slot_v, free_v, victim_v;
  logic [KW-1:0]      key_in;
  cmd_e               cmd;

  // decoded word, held through the apply cycle
  logic [ENTRIES-1:0] sel_q, sel_d;
  act_e               act_q, act_d;
  logic               ins_q, ins_d;
  status_e            st_q, st_d;
  logic [KW-1:0]      key_q;

  // apply cycle signals
  logic [ENTRIES-1:0] below, ge_v, le_v;
  logic [SW-1:0]      sel_id;
  logic [KW-1:0]      sel_key;
  logic               sel_valid;
  logic [KW-1:0]      inj_key;
  logic               inj_valid, inj_pin;

  // result registers
  logic                res_done_q;
  status_e             res_st_q;
  logic [SlotInW-1:0]  res_slot_q;
  logic                res_ev_valid_q;
  logic [KeyInW-1:0]   res_ev_key_q;

  assign accept = start && !busy;

  // fsm next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      FSM_IDLE:  if (accept) fsm_d = FSM_APPLY;
      FSM_APPLY: fsm_d = FSM_IDLE;
      default:   fsm_d = FSM_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy     = 1'b0;
    apply_en = 1'b0;
    unique case (fsm_q)
      FSM_IDLE:  busy = 1'b0;
      FSM_APPLY: begin
        busy     = 1'b1;
        apply_en = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= FSM_IDLE;
    end else begin
      fsm_q <= fsm_d;
    end
  end

  // associative match and victim pick over the row
  assign key_in = KW'(key_i);
  assign cmd    = cmd_e'(command_i);

  always_comb begin
    for (int p = 0; p < ENTRIES; p++) begin
      hit_v[p]  = cell_valid[p] && (cell_key[p] == key_in);
      slot_v[p] = (CW'(cell_id[p]) == CW'(slot_i));
      free_v[p] = !cell_pin[p];
    end
  end

  // least recent unpinned position: isolate lowest set bit
  assign victim_v = free_v & (~free_v + ENTRIES'(1));

  // command decode
  always_comb begin
    sel_d = '0;
    act_d = ACT_NONE;
    ins_d = 1'b0;
    st_d  = ST_MISS;
    unique case (cmd)
      CMD_LOOKUP, CMD_INSERT: begin
        if (|hit_v) begin
          sel_d = hit_v;
          act_d = ACT_MRU;
          st_d  = ST_DONE;
        end else if (cmd == CMD_INSERT) begin
          if (|free_v) begin
            sel_d = victim_v;
            act_d = ACT_MRU;
            ins_d = 1'b1;
            st_d  = ST_INSERTED;
          end else begin
            st_d  = ST_FULL;
          end
        end
      end
      CMD_TOUCH, CMD_DEMOTE, CMD_PIN: begin
        if (|slot_v) begin
          sel_d = slot_v;
          st_d  = ST_DONE;
          if (cmd == CMD_TOUCH) begin
            act_d = ACT_MRU;
          end else if (cmd == CMD_DEMOTE) begin
            act_d = ACT_LRU;
          end else begin
            act_d = ACT_PIN;
          end
        end
      end
      CMD_FLUSH: begin
        act_d = ACT_FLUSH;
        st_d  = ST_DONE;
      end
      default: begin
        st_d = ST_MISS;
      end
    endcase
  end

  // decoded word registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sel_q <= sel_d;
      act_q <= act_d;
      ins_q <= ins_d;
      st_q  <= st_d;
      key_q <= key_in;
    end
  end

  // selected entry, one-hot and-or mux
  always_comb begin
    sel_id    = '0;
    sel_key   = '0;
    sel_valid = 1'b0;
    for (int p = 0; p < ENTRIES; p++) begin
      sel_id    = sel_id    | (cell_id[p]  & {SW{sel_q[p]}});
      sel_key   = sel_key   | (cell_key[p] & {KW{sel_q[p]}});
      sel_valid = sel_valid | (cell_valid[p] & sel_q[p]);
    end
  end

  // shift ranges from the selected position
  assign below = sel_q - ENTRIES'(1);
  assign ge_v  = ~below;
  assign le_v  = below | sel_q;

  // entry written back into the row
  assign inj_key   = ins_q ? key_q : sel_key;
  assign inj_valid = ins_q | sel_valid;
  assign inj_pin   = (act_q == ACT_PIN);

  // per-cell control for the apply cycle
  always_comb begin
    for (int p = 0; p < ENTRIES; p++) begin
      ctrl[p] = '0;
      if (apply_en) begin
        unique case (act_q)
          ACT_MRU: begin
            ctrl[p].load    = (p == ENTRIES - 1);
            ctrl[p].take_hi = ge_v[p] && (p != ENTRIES - 1);
          end
          ACT_LRU: begin
            ctrl[p].load    = (p == 0);
            ctrl[p].take_lo = le_v[p] && (p != 0);
          end
          ACT_PIN:   ctrl[p].load  = sel_q[p];
          ACT_FLUSH: ctrl[p].flush = 1'b1;
          ACT_NONE:  ctrl[p]       = '0;
          default:   ctrl[p]       = '0;
        endcase
      end
    end
  end

  lksm_chain #(
    .ENTRIES(ENTRIES),
    .SW     (SW),
    .KW     (KW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .inj_id_i   (sel_id),
    .inj_key_i  (inj_key),
    .inj_valid_i(inj_valid),
    .inj_pin_i  (inj_pin),
    .id_o       (cell_id),
    .key_o      (cell_key),
    .valid_o    (cell_valid),
    .pin_o      (cell_pin)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_done_q <= 1'b0;
    end else begin
      res_done_q <= apply_en;
    end
  end

  // result word, captured at the end of the apply cycle
  always_ff @(posedge clk_i) begin
    if (apply_en) begin
      res_st_q       <= st_q;
      res_slot_q     <= SlotInW'(sel_id);
      res_ev_valid_q <= ins_q && sel_valid;
      res_ev_key_q   <= (ins_q && sel_valid) ? KeyInW'(sel_key) : '0;
    end
  end

  assign done_o          = res_done_q;
  assign status_o        = res_st_q;
  assign slot_out_o      = res_slot_q;
  assign evicted_valid_o = res_ev_valid_q;
  assign evicted_key_o   = res_ev_key_q;

endmodule

// File: sv/lksm_checker.sv
// lksm_checker: port-level checks on command and result timing
// bound to lru_key_slot_map_core
// depends on lksm_pkg
module lksm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [lksm_pkg::StatusW-1:0] status_o,
  input logic                         evicted_valid_o
);
  import lksm_pkg::*;

  // an accepted word blocks the next one for its apply cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("no busy cycle after an accepted word");

  // every accepted word gives its result strobe once its apply cycle is over
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("result strobe missing after accepted word");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result strobe without a preceding busy cycle");

  // an eviction is only reported with an insert
  a_evict_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_valid_o |-> status_o == ST_INSERTED)
    else $error("eviction reported without insert status");

endmodule

bind lru_key_slot_map_core lksm_checker u_lksm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .evicted_valid_o(evicted_valid_o)
);
